### rtl/bsfn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfn_pkg: shared definitions for the bitmap set with find-next
// Geometry of the bitmap, request codes and the command and status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package bsfn_pkg;

    // Bitmap geometry. WORD_BITS must be a power of two.
    localparam int WORD_BITS  = 64;
    localparam int NUM_WORDS  = 64;
    localparam int POS_W      = 12;
    localparam int COUNT_W    = 13;
    localparam int POS_SPACE  = 1 << POS_W;

    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WORD_IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int UNIVERSE   = (WORD_BITS * NUM_WORDS < POS_SPACE) ?
                                (WORD_BITS * NUM_WORDS) : POS_SPACE;
    localparam int LAST_WORD  = (UNIVERSE - 1) / WORD_BITS;

    // Request modes.
    localparam logic [1:0] MODE_SET   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_TEST  = 2'd2;
    localparam logic [1:0] MODE_FIND  = 2'd3;

    // Kinds of result the controller asks the datapath to produce.
    localparam logic [1:0] RESP_OOR    = 2'd0;
    localparam logic [1:0] RESP_FIND   = 2'd1;
    localparam logic [1:0] RESP_ACCESS = 2'd2;

    typedef struct packed {
        logic       load;
        logic       access_rd;
        logic       scan_init;
        logic       scan_step;
        logic       respond;
        logic [1:0] resp_kind;
        logic       resp_found;
    } cmd_t;

    typedef struct packed {
        logic is_find;
        logic oor;
        logic find_empty;
        logic hit;
        logic chk_last;
    } status_t;

endpackage

### rtl/bsfn_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfn_ctrl: request sequencer
// Steps each request through dispatch, a read-modify-write of one word, or a
// word-by-word scan for the next member.
// ----------------------------------------------------------------------------
module bsfn_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bsfn_pkg::status_t status,
    output bsfn_pkg::cmd_t    cmd
);
    import bsfn_pkg::*;

    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_DISPATCH = 2'd1;
    localparam logic [1:0] ST_ACCESS   = 2'd2;
    localparam logic [1:0] ST_SCAN     = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (status.oor)
                begin
                    cmd.respond   = 1'b1;
                    cmd.resp_kind = RESP_OOR;
                    state_next    = ST_IDLE;
                end
                else if (status.is_find)
                begin
                    if (status.find_empty)
                    begin
                        cmd.respond   = 1'b1;
                        cmd.resp_kind = RESP_FIND;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = ST_SCAN;
                    end
                end
                else
                begin
                    cmd.access_rd = 1'b1;
                    state_next    = ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                cmd.respond   = 1'b1;
                cmd.resp_kind = RESP_ACCESS;
                state_next    = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (status.hit || status.chk_last)
                begin
                    cmd.respond    = 1'b1;
                    cmd.resp_kind  = RESP_FIND;
                    cmd.resp_found = status.hit;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

### rtl/bsfn_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfn_datapath: bitmap storage and result logic
// Holds the bitmap word memory with per-word valid bits, the population
// count, the scan pointers and the registered result.
// ----------------------------------------------------------------------------
module bsfn_datapath
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [1:0]                   mode,
    input  logic [bsfn_pkg::POS_W-1:0]   position,
    input  logic                         from_start,
    input  bsfn_pkg::cmd_t               cmd,
    output bsfn_pkg::status_t            status,
    output logic                         done,
    output logic                         found,
    output logic [bsfn_pkg::POS_W-1:0]   next_position,
    output logic                         is_member,
    output logic [bsfn_pkg::COUNT_W-1:0] member_count,
    output logic                         out_of_range
);
    import bsfn_pkg::*;

    localparam logic [POS_W:0]        UNIV_V      = (POS_W + 1)'(UNIVERSE);
    localparam logic [WORD_IDX_W-1:0] LAST_WORD_V = WORD_IDX_W'(LAST_WORD);

    // Request latch.
    logic [1:0]       req_mode_reg;
    logic [POS_W-1:0] req_pos_reg;
    logic             req_from_start_reg;

    // Word memory; a word whose valid bit is clear reads as zero.
    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] row_valid_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_valid_reg;

    logic [COUNT_W-1:0]    population_reg;
    logic [WORD_IDX_W-1:0] scan_addr_reg;
    logic [WORD_IDX_W-1:0] chk_addr_reg;
    logic                  first_reg;

    logic                  done_reg;
    logic                  found_reg;
    logic [POS_W-1:0]      next_position_reg;
    logic                  is_member_reg;
    logic [COUNT_W-1:0]    member_count_reg;
    logic                  out_of_range_reg;

    logic [WORD_IDX_W-1:0] req_word;
    logic [BIT_W-1:0]      req_bit;
    logic [POS_W:0]        start_pos;
    logic [WORD_IDX_W-1:0] start_word;
    logic [BIT_W-1:0]      start_bit;
    logic                  is_find;
    logic                  rd_en;
    logic [WORD_IDX_W-1:0] rd_addr;
    logic [WORD_BITS-1:0]  word_eff;
    logic [WORD_BITS-1:0]  scan_mask;
    logic [WORD_BITS-1:0]  masked;
    logic [WORD_BITS-1:0]  lsb;
    logic [BIT_W-1:0]      hit_bit;
    logic [POS_W-1:0]      found_pos;
    logic [WORD_BITS-1:0]  bit_mask;
    logic                  was;
    logic                  wr_en;
    logic [WORD_BITS-1:0]  new_word;
    logic [COUNT_W-1:0]    pop_next;
    logic                  member_next;

    assign req_word   = WORD_IDX_W'(req_pos_reg >> BIT_W);
    assign req_bit    = req_pos_reg[BIT_W-1:0];
    assign is_find    = (req_mode_reg == MODE_FIND);

    // A find from the start includes position 0; otherwise it begins just
    // after the given position.
    assign start_pos  = req_from_start_reg ? '0
                      : ((POS_W + 1)'({1'b0, req_pos_reg}) + (POS_W + 1)'(1));
    assign start_word = WORD_IDX_W'(start_pos >> BIT_W);
    assign start_bit  = start_pos[BIT_W-1:0];

    assign status.is_find    = is_find;
    assign status.oor        = ({1'b0, req_pos_reg} >= UNIV_V)
                             && !(is_find && req_from_start_reg);
    assign status.find_empty = (start_pos >= UNIV_V);
    assign status.hit        = |masked;
    assign status.chk_last   = (chk_addr_reg == LAST_WORD_V);

    assign rd_en   = cmd.access_rd | cmd.scan_init | cmd.scan_step;
    assign rd_addr = cmd.access_rd ? req_word
                   : (cmd.scan_init ? start_word : scan_addr_reg);

    assign word_eff  = rd_valid_reg ? rd_data_reg : '0;
    assign scan_mask = first_reg ? ({WORD_BITS{1'b1}} << start_bit) : '1;
    assign masked    = word_eff & scan_mask;
    assign lsb       = masked & (~masked + WORD_BITS'(1));

    always_comb
    begin
        hit_bit = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (lsb[i])
            begin
                hit_bit = hit_bit | BIT_W'(i);
            end
        end
    end

    assign found_pos = POS_W'({chk_addr_reg, hit_bit});

    assign bit_mask = WORD_BITS'(1) << req_bit;
    assign was      = |(word_eff & bit_mask);
    assign wr_en    = cmd.respond && (cmd.resp_kind == RESP_ACCESS)
                    && ((req_mode_reg == MODE_SET) || (req_mode_reg == MODE_CLEAR));

    always_comb
    begin
        new_word    = word_eff;
        pop_next    = population_reg;
        member_next = was;
        if (req_mode_reg == MODE_SET)
        begin
            new_word    = word_eff | bit_mask;
            member_next = 1'b1;
            if (!was)
            begin
                pop_next = population_reg + COUNT_W'(1);
            end
        end
        else if (req_mode_reg == MODE_CLEAR)
        begin
            new_word    = word_eff & ~bit_mask;
            member_next = 1'b0;
            if (was)
            begin
                pop_next = population_reg - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_mode_reg       <= mode;
            req_pos_reg        <= position;
            req_from_start_reg <= from_start;
        end
    end

    // Word memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[req_word] <= new_word;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg  <= '0;
            rd_valid_reg   <= 1'b0;
            population_reg <= '0;
            scan_addr_reg  <= '0;
            chk_addr_reg   <= '0;
            first_reg      <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.respond;
            if (wr_en)
            begin
                row_valid_reg[req_word] <= 1'b1;
                population_reg          <= pop_next;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
            if (cmd.scan_init)
            begin
                scan_addr_reg <= start_word + WORD_IDX_W'(1);
                chk_addr_reg  <= start_word;
                first_reg     <= 1'b1;
            end
            else if (cmd.scan_step)
            begin
                scan_addr_reg <= scan_addr_reg + WORD_IDX_W'(1);
                chk_addr_reg  <= scan_addr_reg;
                first_reg     <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            unique case (cmd.resp_kind)
                RESP_OOR:
                begin
                    found_reg         <= 1'b0;
                    next_position_reg <= '0;
                    is_member_reg     <= 1'b0;
                    member_count_reg  <= population_reg;
                    out_of_range_reg  <= 1'b1;
                end
                RESP_FIND:
                begin
                    found_reg         <= cmd.resp_found;
                    next_position_reg <= cmd.resp_found ? found_pos : '0;
                    is_member_reg     <= 1'b0;
                    member_count_reg  <= population_reg;
                    out_of_range_reg  <= 1'b0;
                end
                RESP_ACCESS:
                begin
                    found_reg         <= 1'b0;
                    next_position_reg <= '0;
                    is_member_reg     <= member_next;
                    member_count_reg  <= pop_next;
                    out_of_range_reg  <= 1'b0;
                end
                default:
                begin
                    found_reg         <= 1'b0;
                    next_position_reg <= '0;
                    is_member_reg     <= 1'b0;
                    member_count_reg  <= population_reg;
                    out_of_range_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign done          = done_reg;
    assign found         = found_reg;
    assign next_position = next_position_reg;
    assign is_member     = is_member_reg;
    assign member_count  = member_count_reg;
    assign out_of_range  = out_of_range_reg;

endmodule

### rtl/bitmap_set_find_next.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_set_find_next: bitmap set with set, clear, test and find-next
// Set/clear/test read the word, then respond (set and clear write it back); out of range responds at once.
// Find examines one word per cycle until a hit or the last word, 64 words at most.
// The result strobe done is high for one cycle, the first cycle with busy low, and the
// next request may go in then.
// The word memory's single read port sets the scan rate; the receiver cannot stall.
// Reset empties the set at once through per-word valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module bitmap_set_find_next
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   mode,
    input  logic [bsfn_pkg::POS_W-1:0]   position,
    input  logic                         from_start,
    output logic                         done,
    output logic                         found,
    output logic [bsfn_pkg::POS_W-1:0]   next_position,
    output logic                         is_member,
    output logic [bsfn_pkg::COUNT_W-1:0] member_count,
    output logic                         out_of_range
);
    import bsfn_pkg::*;

    cmd_t    cmd;
    status_t status;

    bsfn_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    bsfn_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (mode),
        .position      (position),
        .from_start    (from_start),
        .cmd           (cmd),
        .status        (status),
        .done          (done),
        .found         (found),
        .next_position (next_position),
        .is_member     (is_member),
        .member_count  (member_count),
        .out_of_range  (out_of_range)
    );

endmodule
